@@ src/jt1078_frame_packetizer_defines.svh @@
// Assertion macros for the JT/T 1078 frame packetizer.
// Included by the top level; relies on a clock named clk and a reset named rst.
`ifndef JT1078_FRAME_PACKETIZER_DEFINES_SVH
`define JT1078_FRAME_PACKETIZER_DEFINES_SVH
`ifndef SYNTHESIS
`define JFP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define JFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define JFP_ASSERT_IMPL(label, ante, cons)
`define JFP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ src/jfp_pkg.sv @@
// Shared types and constants of the JT/T 1078 frame packetizer.
// No dependencies; imported by every module of the block.
package jfp_pkg;

  localparam int RateW = 10;
  localparam int LenW  = 16;
  localparam int SeqW  = 16;
  localparam int TimeW = 64;
  localparam int StepW = $clog2(RateW);

  localparam logic [LenW-1:0]  MaxPayload        = 16'd1024;
  localparam logic [RateW-1:0] DefaultRate       = 10'd25;
  localparam logic [RateW-1:0] DefaultInterval   = 10'd40;
  localparam logic [RateW-1:0] IntervalNumerator = 10'd1000;
  localparam logic [TimeW-1:0] AudioStepMs       = 64'd20;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  localparam logic KIND_VIDEO = 1'b0;
  localparam logic KIND_AUDIO = 1'b1;

  localparam logic [1:0] CODEC_H265  = 2'd1;
  localparam logic [1:0] CODEC_G711U = 2'd1;
  localparam logic [1:0] CODEC_AAC   = 2'd2;

  localparam logic [6:0] PT_H265  = 7'd99;
  localparam logic [6:0] PT_H264  = 7'd98;
  localparam logic [6:0] PT_G711U = 7'd7;
  localparam logic [6:0] PT_AAC   = 7'd19;
  localparam logic [6:0] PT_AUDIO = 7'd6;

  localparam logic [1:0] POS_ATOMIC = 2'd0;
  localparam logic [1:0] POS_FIRST  = 2'd1;
  localparam logic [1:0] POS_MIDDLE = 2'd2;
  localparam logic [1:0] POS_LAST   = 2'd3;

  localparam logic [1:0] CLS_I     = 2'd0;
  localparam logic [1:0] CLS_P     = 2'd1;
  localparam logic [1:0] CLS_AUDIO = 2'd2;

  typedef struct packed {
    logic             audio;
    logic [6:0]       payload_type;
    logic [1:0]       frame_class;
    logic [TimeW-1:0] timestamp;
    logic [15:0]      key_interval;
    logic [RateW-1:0] interval_ms;
    logic [LenW-1:0]  frame_length;
  } job_t;

  typedef enum logic {
    BK_IDLE,
    BK_SEND
  } back_state_t;

endpackage

@@ src/jt1078_frame_packetizer.sv @@
// JT/T 1078 frame packetizer: one packet header descriptor per chunk of a frame.
// A frame's first descriptor is registered after its job is queued and the back
// end has moved from idle to send; it emits one descriptor a cycle while pkt_stall
// is low, returns to idle after each frame, and a 4-deep job queue decouples it.
// A frame_rate write holds off frame requests while the interval divider is busy.
// Reset (rst, synchronous) clears counters, clocks, queue and pkt_valid; frame_rate is 25.
`include "jt1078_frame_packetizer_defines.svh"
module jt1078_frame_packetizer import jfp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             frame_valid,
  output logic             frame_stall,
  input  logic             kind,
  input  logic [1:0]       codec,
  input  logic             key_frame,
  input  logic [LenW-1:0]  frame_length,
  output logic             pkt_valid,
  input  logic             pkt_stall,
  output logic [6:0]       payload_type,
  output logic [SeqW-1:0]  sequence_res,
  output logic [1:0]       packet_position,
  output logic [1:0]       frame_class,
  output logic [TimeW-1:0] timestamp,
  output logic [15:0]      key_interval,
  output logic [RateW-1:0] interval_ms,
  output logic [LenW-1:0]  chunk_bytes,
  output logic [LenW-1:0]  payload_offset,
  output logic             last_of_frame
);

  logic [RateW-1:0] frame_rate;
  logic [RateW-1:0] rate_eff;
  logic [RateW-1:0] fint;
  logic             cfg_wr;
  logic             div_busy;
  logic             q_push;
  logic             q_pop;
  logic             q_empty;
  logic             q_full;
  job_t             q_wdata;
  job_t             q_head;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && !paddr[2];
  assign rate_eff = (pwdata[RateW-1:0] == '0) ? DefaultRate : pwdata[RateW-1:0];
  assign prdata   = paddr[2] ? 32'd0 : {{(32-RateW){1'b0}}, frame_rate};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rate <= DefaultRate;
    end else if (cfg_wr) begin
      frame_rate <= pwdata[RateW-1:0];
    end
  end

  jfp_intdiv u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cfg_wr),
    .divisor  (rate_eff),
    .busy     (div_busy),
    .quotient (fint)
  );

  jfp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .kind         (kind),
    .codec        (codec),
    .key_frame    (key_frame),
    .frame_length (frame_length),
    .fint         (fint),
    .div_busy     (div_busy),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  jfp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .head  (q_head),
    .empty (q_empty),
    .full  (q_full)
  );

  jfp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (q_head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .pkt_valid       (pkt_valid),
    .pkt_stall       (pkt_stall),
    .payload_type    (payload_type),
    .sequence_res    (sequence_res),
    .packet_position (packet_position),
    .frame_class     (frame_class),
    .timestamp       (timestamp),
    .key_interval    (key_interval),
    .interval_ms     (interval_ms),
    .chunk_bytes     (chunk_bytes),
    .payload_offset  (payload_offset),
    .last_of_frame   (last_of_frame)
  );

  `JFP_ASSERT_NEXT(a_cfg_holds_frames, cfg_wr, frame_stall)
  `JFP_ASSERT_IMPL(a_last_matches_pos, pkt_valid, last_of_frame == (packet_position == POS_LAST || packet_position == POS_ATOMIC))
  `JFP_ASSERT_IMPL(a_audio_atomic, pkt_valid && frame_class == CLS_AUDIO, packet_position == POS_ATOMIC && interval_ms == '0)
  `JFP_ASSERT_IMPL(a_video_chunk_bound, pkt_valid && frame_class != CLS_AUDIO, chunk_bytes <= MaxPayload && chunk_bytes != '0)

endmodule

@@ src/jfp_intdiv.sv @@
// Restoring divider: frame interval = 1000 / frame rate, one quotient bit a cycle.
// Depends on jfp_pkg.
module jfp_intdiv import jfp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [RateW-1:0] divisor,
  output logic             busy,
  output logic [RateW-1:0] quotient
);

  logic [RateW-1:0] dvs;
  logic [RateW-1:0] num;
  logic [RateW-1:0] rem;
  logic [StepW-1:0] cnt;
  logic [RateW:0]   trial;
  logic             fits;

  assign trial = {rem, num[RateW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      quotient <= DefaultInterval;
      cnt      <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      quotient <= '0;
      cnt      <= StepW'(RateW - 1);
    end else if (busy) begin
      quotient <= {quotient[RateW-2:0], fits};
      cnt      <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      num <= IntervalNumerator;
      rem <= '0;
    end else if (busy) begin
      num <= {num[RateW-2:0], 1'b0};
      rem <= fits ? RateW'(trial - {1'b0, dvs}) : trial[RateW-1:0];
    end
  end

endmodule

@@ src/jfp_queue.sv @@
// Short job queue between the frame front end and the packet back end.
// Depends on jfp_pkg (job_t, QDepth).
module jfp_queue import jfp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wdata,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  job_t             entries [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QPtrW:0]   count;
  logic             do_push;
  logic             do_pop;

  assign empty   = count == '0;
  assign full    = count == (QPtrW+1)'(QDepth);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

@@ src/jfp_front.sv @@
// Frame front end: takes frame requests, keeps the frame counters and clocks,
// and queues one job per frame that produces packets. Depends on jfp_pkg.
module jfp_front import jfp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             frame_valid,
  output logic             frame_stall,
  input  logic             kind,
  input  logic [1:0]       codec,
  input  logic             key_frame,
  input  logic [LenW-1:0]  frame_length,
  input  logic [RateW-1:0] fint,
  input  logic             div_busy,
  input  logic             q_full,
  output logic             q_push,
  output job_t             q_data
);

  logic [15:0]       frames_since_key;
  logic [15:0]       frames_since_key_next;
  logic [TimeW-1:0]  video_time;
  logic [TimeW-1:0]  audio_time;
  logic [RateW+15:0] kint_full;
  logic              accept;
  logic              is_audio;

  assign frame_stall = div_busy || q_full;
  assign accept      = frame_valid && !frame_stall;
  assign is_audio    = kind == KIND_AUDIO;

  assign frames_since_key_next = key_frame ? 16'd1 : frames_since_key + 16'd1;
  assign kint_full             = frames_since_key_next * fint;

  always_comb begin
    q_data.audio        = is_audio;
    q_data.frame_length = frame_length;
    if (is_audio) begin
      case (codec)
        CODEC_G711U: q_data.payload_type = PT_G711U;
        CODEC_AAC:   q_data.payload_type = PT_AAC;
        default:     q_data.payload_type = PT_AUDIO;
      endcase
      q_data.frame_class  = CLS_AUDIO;
      q_data.timestamp    = audio_time;
      q_data.key_interval = '0;
      q_data.interval_ms  = '0;
    end else begin
      q_data.payload_type = (codec == CODEC_H265) ? PT_H265 : PT_H264;
      q_data.frame_class  = key_frame ? CLS_I : CLS_P;
      q_data.timestamp    = video_time;
      q_data.key_interval = kint_full[15:0];
      q_data.interval_ms  = fint;
    end
  end

  // empty video frames only advance the counters
  assign q_push = accept && (is_audio || frame_length != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_since_key <= '0;
      video_time       <= '0;
      audio_time       <= '0;
    end else if (accept) begin
      if (is_audio) begin
        audio_time <= audio_time + AudioStepMs;
      end else begin
        frames_since_key <= frames_since_key_next;
        video_time       <= video_time + TimeW'(fint);
      end
    end
  end

endmodule

@@ src/jfp_back.sv @@
// Packet back end: splits the queued job into chunks, one descriptor a cycle unless
// stalled or idle, numbered from the shared sequence counter. Depends on jfp_pkg.
module jfp_back import jfp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  job_t             head,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             pkt_valid,
  input  logic             pkt_stall,
  output logic [6:0]       payload_type,
  output logic [SeqW-1:0]  sequence_res,
  output logic [1:0]       packet_position,
  output logic [1:0]       frame_class,
  output logic [TimeW-1:0] timestamp,
  output logic [15:0]      key_interval,
  output logic [RateW-1:0] interval_ms,
  output logic [LenW-1:0]  chunk_bytes,
  output logic [LenW-1:0]  payload_offset,
  output logic             last_of_frame
);

  back_state_t     state;
  back_state_t     state_next;
  logic [LenW-1:0] bytes_left;
  logic [LenW-1:0] offset;
  logic [SeqW-1:0] seq;
  logic            first;
  logic            load;
  logic            tail;
  logic            last;
  logic            multi;
  logic [LenW-1:0] chunk;
  logic [1:0]      pos;

  assign tail  = bytes_left <= MaxPayload;
  assign last  = head.audio || tail;
  assign multi = !head.audio && head.frame_length > MaxPayload;
  assign chunk = (head.audio || tail) ? bytes_left : MaxPayload;

  always_comb begin
    if (!multi) begin
      pos = POS_ATOMIC;
    end else if (first) begin
      pos = POS_FIRST;
    end else if (tail) begin
      pos = POS_LAST;
    end else begin
      pos = POS_MIDDLE;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (!q_empty) state_next = BK_SEND;
      BK_SEND: if (load && last) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    load  = (state == BK_SEND) && (!pkt_valid || !pkt_stall);
    q_pop = load && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      pkt_valid <= 1'b0;
      seq       <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        pkt_valid <= 1'b1;
        seq       <= seq + 1'b1;
      end else if (!pkt_stall) begin
        pkt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE) begin
      bytes_left <= head.frame_length;
      offset     <= '0;
      first      <= 1'b1;
    end else if (load) begin
      bytes_left <= bytes_left - chunk;
      offset     <= offset + chunk;
      first      <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      payload_type    <= head.payload_type;
      sequence_res    <= seq;
      packet_position <= pos;
      frame_class     <= head.frame_class;
      timestamp       <= head.timestamp;
      key_interval    <= head.key_interval;
      interval_ms     <= head.interval_ms;
      chunk_bytes     <= chunk;
      payload_offset  <= offset;
      last_of_frame   <= last;
    end
  end

endmodule

@@ test/tb_jt1078_frame_packetizer.sv @@
// Self-checking testbench for jt1078_frame_packetizer: directed frames, then random frames
// across several frame_rate settings, random frame gaps, and random and long packet stalls.
// Depends on jfp_pkg and the jt1078_frame_packetizer RTL only.
module tb_jt1078_frame_packetizer;
  import jfp_pkg::*;

  localparam int IdlePct     = 24;
  localparam int HoldCycles  = 400;
  localparam int SettleCyc   = 20;
  localparam int CycleLimit  = 500000;
  localparam int ItemsPerRun = 46;
  localparam int MaxPkts     = 64;
  localparam int ChunkMax    = MaxPayload;

  localparam logic [2:0] REG_FRAME_RATE = 3'd0;
  localparam logic [2:0] REG_SPARE      = 3'd4;

  typedef struct packed {
    logic [6:0]       payload_type;
    logic [SeqW-1:0]  sequence_res;
    logic [1:0]       packet_position;
    logic [1:0]       frame_class;
    logic [TimeW-1:0] timestamp;
    logic [15:0]      key_interval;
    logic [RateW-1:0] interval_ms;
    logic [LenW-1:0]  chunk_bytes;
    logic [LenW-1:0]  payload_offset;
    logic             last_of_frame;
  } pkt_desc_t;

  typedef struct packed {
    logic            kind;
    logic [1:0]      codec;
    logic            key_frame;
    logic [LenW-1:0] frame_length;
    logic            typed;
    pkt_desc_t       want;
  } frame_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic frame_valid = 1'b0;
  logic frame_stall;
  logic kind = 1'b0;
  logic [1:0] codec = '0;
  logic key_frame = 1'b0;
  logic [LenW-1:0] frame_length = '0;
  logic pkt_valid;
  logic pkt_stall = 1'b0;
  logic [6:0] payload_type;
  logic [SeqW-1:0] sequence_res;
  logic [1:0] packet_position;
  logic [1:0] frame_class;
  logic [TimeW-1:0] timestamp;
  logic [15:0] key_interval;
  logic [RateW-1:0] interval_ms;
  logic [LenW-1:0] chunk_bytes;
  logic [LenW-1:0] payload_offset;
  logic last_of_frame;

  // predictor state
  logic [RateW-1:0] rate_cfg = DefaultRate;
  logic [SeqW-1:0]  seq_next = '0;
  logic [15:0]      since_key = '0;
  logic [TimeW-1:0] video_ms = '0;
  logic [TimeW-1:0] audio_ms = '0;
  pkt_desc_t        pending_pkts [$];

  int  mismatches = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;
  int  hold_req = 0;
  int  hold_ack = 0;
  int  hold_left = 0;

  jt1078_frame_packetizer dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .frame_valid, .frame_stall, .kind, .codec, .key_frame, .frame_length,
    .pkt_valid, .pkt_stall, .payload_type, .sequence_res, .packet_position,
    .frame_class, .timestamp, .key_interval, .interval_ms, .chunk_bytes,
    .payload_offset, .last_of_frame
  );

  always #2 clk = ~clk;

  task automatic field_check(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  task automatic packetize_frame(input frame_req_t req);
    pkt_desc_t d;
    int fps, fint, count, left, offset, idx, chunk;
    d = '0;
    fps = (rate_cfg == 0) ? int'(DefaultRate) : int'(rate_cfg);
    fint = int'(IntervalNumerator) / fps;
    if (req.kind == KIND_AUDIO) begin
      d.payload_type = (req.codec == CODEC_G711U) ? PT_G711U :
                       (req.codec == CODEC_AAC) ? PT_AAC : PT_AUDIO;
      d.sequence_res = seq_next;
      d.packet_position = POS_ATOMIC;
      d.frame_class = CLS_AUDIO;
      d.timestamp = audio_ms;
      d.chunk_bytes = req.frame_length;
      d.last_of_frame = 1'b1;
      pending_pkts.push_back(d);
      seq_next++;
      audio_ms += AudioStepMs;
    end else begin
      since_key = req.key_frame ? 16'd1 : since_key + 16'd1;
      d.payload_type = (req.codec == CODEC_H265) ? PT_H265 : PT_H264;
      d.frame_class = req.key_frame ? CLS_I : CLS_P;
      d.timestamp = video_ms;
      d.key_interval = 16'(int'(since_key) * fint);
      d.interval_ms = RateW'(fint);
      left = int'(req.frame_length);
      count = (left + ChunkMax - 1) / ChunkMax;
      offset = 0;
      idx = 0;
      while (left > 0 && idx < MaxPkts) begin
        chunk = (left > ChunkMax) ? ChunkMax : left;
        if (count <= 1) d.packet_position = POS_ATOMIC;
        else if (idx == 0) d.packet_position = POS_FIRST;
        else if (left <= ChunkMax) d.packet_position = POS_LAST;
        else d.packet_position = POS_MIDDLE;
        d.sequence_res = seq_next;
        d.chunk_bytes = LenW'(chunk);
        d.payload_offset = LenW'(offset);
        d.last_of_frame = (left <= ChunkMax);
        pending_pkts.push_back(d);
        seq_next++;
        idx++;
        offset += chunk;
        left -= chunk;
      end
      video_ms += TimeW'(fint);
    end
  endtask

  function automatic frame_req_t plain_row(logic k, logic [1:0] c, logic key,
                                           logic [LenW-1:0] len);
    frame_req_t r;
    r = '0;
    r.kind = k;
    r.codec = c;
    r.key_frame = key;
    r.frame_length = len;
    return r;
  endfunction

  // single atomic packet with the whole frame, fields written out by hand
  function automatic frame_req_t typed_row(logic k, logic [1:0] c, logic key,
      logic [LenW-1:0] len, logic [6:0] pt, logic [SeqW-1:0] seq, logic [1:0] cls,
      logic [TimeW-1:0] ts, logic [15:0] kint, logic [RateW-1:0] fint);
    frame_req_t r;
    r = plain_row(k, c, key, len);
    r.typed = 1'b1;
    r.want.payload_type = pt;
    r.want.sequence_res = seq;
    r.want.packet_position = POS_ATOMIC;
    r.want.frame_class = cls;
    r.want.timestamp = ts;
    r.want.key_interval = kint;
    r.want.interval_ms = fint;
    r.want.chunk_bytes = len;
    r.want.payload_offset = '0;
    r.want.last_of_frame = 1'b1;
    return r;
  endfunction

  function automatic frame_req_t random_frame();
    frame_req_t r;
    int pick;
    logic [LenW-1:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 8) len = '0;
    else if (pick < 45) len = LenW'($urandom_range(1, ChunkMax - 1));
    else if (pick < 60) len = LenW'($urandom_range(1, 8) * ChunkMax + $urandom_range(0, 2) - 1);
    else if (pick < 90) len = LenW'($urandom_range(1, 8192));
    else len = LenW'($urandom_range(0, 65535));
    r = plain_row($urandom_range(0, 99) < 30 ? KIND_AUDIO : KIND_VIDEO,
                  2'($urandom_range(0, 3)), $urandom_range(0, 99) < 20, len);
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer_frame(input frame_req_t req);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      frame_valid <= 1'b0;
      @(negedge clk);
    end
    frame_valid <= 1'b1;
    kind <= req.kind;
    codec <= req.codec;
    key_frame <= req.key_frame;
    frame_length <= req.frame_length;
    do @(posedge clk); while (frame_stall);
    packetize_frame(req);
    if (req.typed)
      pending_pkts[pending_pkts.size() - 1] = req.want;
    @(negedge clk);
  endtask

  task automatic drain_results();
    frame_valid <= 1'b0;
    while (pending_pkts.size() != 0) @(negedge clk);
    repeat (SettleCyc) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == REG_FRAME_RATE) rate_cfg = value[RateW-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_rate();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= REG_FRAME_RATE;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    field_check("frame_rate", rate_cfg, prdata[RateW-1:0]);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    pkt_stall <= (hold_left != 0) || (!calm && $urandom_range(0, 99) < IdlePct);
  end

  always @(posedge clk) begin
    pkt_desc_t want;
    if (!rst && pkt_valid && !pkt_stall) begin
      if (pending_pkts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected packet: seq %0d size %0d", sequence_res, chunk_bytes);
      end else begin
        want = pending_pkts.pop_front();
        field_check("payload_type", want.payload_type, payload_type);
        field_check("sequence_res", want.sequence_res, sequence_res);
        field_check("packet_position", want.packet_position, packet_position);
        field_check("frame_class", want.frame_class, frame_class);
        field_check("timestamp", want.timestamp, timestamp);
        field_check("key_interval", want.key_interval, key_interval);
        field_check("interval_ms", want.interval_ms, interval_ms);
        field_check("chunk_bytes", want.chunk_bytes, chunk_bytes);
        field_check("payload_offset", want.payload_offset, payload_offset);
        field_check("last_of_frame", want.last_of_frame, last_of_frame);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_jt1078_frame_packetizer: errors");
      $finish;
    end
  end

  initial begin
    frame_req_t rows [$];
    int rate_plan [8];
    rate_plan = '{0, 1000, 1, 1023, 1001, 7, $urandom_range(2, 999), 25};

    rows.push_back(typed_row(KIND_AUDIO, CODEC_G711U, 1'b0, 16'd0, PT_G711U, 16'd0,
                             CLS_AUDIO, 64'd0, 16'd0, 10'd0));
    rows.push_back(typed_row(KIND_VIDEO, CODEC_H265, 1'b1, 16'd1024, PT_H265, 16'd1,
                             CLS_I, 64'd0, 16'd40, DefaultInterval));
    rows.push_back(typed_row(KIND_VIDEO, 2'd0, 1'b0, 16'd1, PT_H264, 16'd2,
                             CLS_P, 64'd40, 16'd80, DefaultInterval));
    rows.push_back(typed_row(KIND_AUDIO, CODEC_AAC, 1'b0, 16'hFFFF, PT_AAC, 16'd3,
                             CLS_AUDIO, 64'd20, 16'd0, 10'd0));
    rows.push_back(typed_row(KIND_AUDIO, 2'd3, 1'b1, 16'd1, PT_AUDIO, 16'd4,
                             CLS_AUDIO, 64'd40, 16'd0, 10'd0));
    rows.push_back(plain_row(KIND_VIDEO, CODEC_H265, 1'b1, 16'hFFFF));
    rows.push_back(plain_row(KIND_VIDEO, 2'd0, 1'b0, 16'd0));
    rows.push_back(plain_row(KIND_VIDEO, 2'd3, 1'b0, 16'd1025));
    rows.push_back(plain_row(KIND_VIDEO, 2'd2, 1'b0, 16'd3072));
    rows.push_back(plain_row(KIND_VIDEO, 2'd0, 1'b1, 16'd1023));
    rows.push_back(plain_row(KIND_AUDIO, 2'd0, 1'b0, 16'd32768));
    rows.push_back(plain_row(KIND_VIDEO, CODEC_H265, 1'b0, 16'd2048));
    rows.push_back(plain_row(KIND_VIDEO, 2'd0, 1'b0, 16'hFFFF));
    rows.push_back(plain_row(KIND_VIDEO, 2'd0, 1'b1, 16'd0));
    rows.push_back(plain_row(KIND_VIDEO, 2'd0, 1'b0, 16'd5000));
    rows.push_back(plain_row(KIND_AUDIO, CODEC_AAC, 1'b0, 16'd1024));
    rows.push_back(plain_row(KIND_VIDEO, CODEC_H265, 1'b0, 16'd64512));

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    check_rate();

    foreach (rows[i]) offer_frame(rows[i]);
    drain_results();

    for (int p = 0; p < 8; p++) begin
      write_reg(REG_FRAME_RATE, 32'(rate_plan[p]));
      if (p == 3) write_reg(REG_SPARE, $urandom);
      check_rate();
      calm = (p == 2);
      for (int i = 0; i < ItemsPerRun; i++) begin
        if (p == 1 && i == 8) hold_req++;
        if (p == 4 && i == 20) drain_results();
        offer_frame(random_frame());
      end
      drain_results();
    end
    calm = 1'b0;

    repeat (SettleCyc) @(negedge clk);
    if (mismatches == 0)
      $display("tb_jt1078_frame_packetizer: clean");
    else
      $display("tb_jt1078_frame_packetizer: errors");
    $finish;
  end

endmodule
